// ===== hdl/kalman_filter_2state_cv_defines.svh =====
// Assertion macros shared by the filter RTL.
`ifndef KALMAN_FILTER_2STATE_CV_DEFINES_SVH
`define KALMAN_FILTER_2STATE_CV_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KFCV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define KFCV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/kfcv_pkg.sv =====
`default_nettype none
package kfcv_pkg;

	// Number format.
	localparam int DW = 32;
	localparam int FB = 16;
	localparam int VW = DW - 1;
	localparam int WW = 56;
	localparam int NUM_W = DW + FB;
	localparam int SW = DW + 1;
	localparam int CNT_W = $clog2(NUM_W);
	localparam int REG_W = 32;
	localparam int IDX_W = 3;

	localparam logic signed [WW-1:0] SMAX_W = (WW'(1) <<< (DW - 1)) - WW'(1);
	localparam logic signed [WW-1:0] SMIN_W = -SMAX_W - WW'(1);

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_MEAS_NOISE = 3'd0;
	localparam logic [IDX_W-1:0] REG_STEP_DT    = 3'd1;
	localparam logic [IDX_W-1:0] REG_PROC_Q_PP  = 3'd2;
	localparam logic [IDX_W-1:0] REG_PROC_Q_PV  = 3'd3;
	localparam logic [IDX_W-1:0] REG_PROC_Q_VV  = 3'd4;
	localparam logic [IDX_W-1:0] REG_DRIVE_POS  = 3'd5;
	localparam logic [IDX_W-1:0] REG_DRIVE_VEL  = 3'd6;
	localparam logic [IDX_W-1:0] REG_INIT_COV   = 3'd7;

	// Register reset values.
	localparam logic [VW-1:0] RST_MEAS_NOISE = 31'd65536;
	localparam logic signed [DW-1:0] RST_STEP_DT = 32'sd65536;
	localparam logic [VW-1:0] RST_INIT_COV = 31'd65536000;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_WB   = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	// Multiply operations in program order.
	localparam logic [3:0] OP_K0PP = 4'd0;
	localparam logic [3:0] OP_K1PV = 4'd1;
	localparam logic [3:0] OP_K0PV = 4'd2;
	localparam logic [3:0] OP_K0Y  = 4'd3;
	localparam logic [3:0] OP_K1Y  = 4'd4;
	localparam logic [3:0] OP_DTV  = 4'd5;
	localparam logic [3:0] OP_DTVV = 4'd6;
	localparam logic [3:0] OP_DTPV = 4'd7;
	localparam logic [3:0] OP_DTT  = 4'd8;

	typedef struct packed {
		logic signed [DW-1:0] meas;
	} meas_t;

	typedef struct packed {
		logic signed [DW-1:0] est_pos;
		logic signed [DW-1:0] est_vel;
		logic [VW-1:0]        cov_pp;
		logic signed [DW-1:0] cov_pv;
		logic [VW-1:0]        cov_vv;
		logic                 div_fault;
	} est_t;

	// Clamp a wide value to the signed data range.
	function automatic logic signed [DW-1:0] sat_s(input logic signed [WW-1:0] v);
		logic signed [DW-1:0] r;
		if (v > SMAX_W) r = SMAX_W[DW-1:0];
		else if (v < SMIN_W) r = SMIN_W[DW-1:0];
		else r = v[DW-1:0];
		return r;
	endfunction

	// Clamp a wide value to [0, signed maximum].
	function automatic logic signed [DW-1:0] sat_u(input logic signed [WW-1:0] v);
		logic signed [DW-1:0] r;
		if (v > SMAX_W) r = SMAX_W[DW-1:0];
		else if (v < 0) r = '0;
		else r = v[DW-1:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/kfcv_stream_if.sv =====
`default_nettype none
interface kfcv_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/kalman_filter_2state_cv.sv =====
// Each accepted beat runs two restoring divisions for the gains, then nine passes of one
// shared multiplier, each a multiply state and a write-back state; when the innovation
// variance is zero the divisions are skipped and only the prediction passes run.
// The sequencer takes a new beat only when idle, after the last result has been loaded.
// Reset (arst_n low) restores the register defaults and loads the state and covariance.
`default_nettype none
`include "kalman_filter_2state_cv_defines.svh"
module kalman_filter_2state_cv (
	input  wire                             clk,
	input  wire                             arst_n,
	kfcv_stream_if.sink                     sample,
	kfcv_stream_if.source                   result,
	input  wire                             cfg_we,
	input  wire [kfcv_pkg::IDX_W-1:0]       cfg_index,
	input  wire [kfcv_pkg::REG_W-1:0]       cfg_data
);
	import kfcv_pkg::*;

	logic [2:0] state_q;
	logic [3:0] op_q;
	logic [CNT_W-1:0] cnt_q;
	logic div_sel_q, div_neg_q, fault_q;
	logic [SW-1:0] s_q;
	logic [SW-1:0] rem_q;
	logic [NUM_W-1:0] num_q;

	logic [VW-1:0] meas_noise_q, proc_q_pp_q, proc_q_vv_q, init_cov_q;
	logic signed [DW-1:0] step_dt_q, proc_q_pv_q, drive_pos_q, drive_vel_q;
	logic signed [DW-1:0] pos_q, vel_q, p_pp_q, p_pv_q, p_vv_q;
	logic signed [DW-1:0] y_q, k0_q, k1_q, t_q;
	logic signed [WW-1:0] acc_q;
	logic signed [2*DW-1:0] prod_q;
	logic out_valid_q;
	est_t out_q;

	// Start-of-beat arithmetic: innovation and innovation variance.
	logic [SW-1:0] s_new;
	logic signed [DW-1:0] y_new;
	logic fault_new;
	assign s_new = {1'b0, p_pp_q} + SW'(meas_noise_q);
	assign fault_new = (s_new == '0);
	assign y_new = sat_s(WW'(sample.data.meas) - WW'(pos_q));

	logic accept;
	assign sample.ready = (state_q == ST_IDLE);
	assign accept = sample.valid && sample.ready;

	// Divider step: one quotient bit per cycle.
	logic [SW:0] trial;
	logic ge;
	logic [NUM_W-1:0] quot;
	logic signed [DW-1:0] k_new;
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge = trial >= {1'b0, s_q};
	assign quot = {num_q[NUM_W-2:0], ge};
	assign k_new = div_neg_q ? sat_s(-WW'(quot)) : sat_s(WW'(quot));

	// Dividend magnitude for the second division.
	logic [DW-1:0] pv_mag;
	assign pv_mag = p_pv_q[DW-1] ? DW'(-p_pv_q) : DW'(p_pv_q);

	// Operand selection for the shared multiplier.
	logic signed [DW-1:0] mul_a, mul_b;
	always_comb begin
		case (op_q)
			OP_K0PP: begin mul_a = k0_q; mul_b = p_pp_q; end
			OP_K1PV: begin mul_a = k1_q; mul_b = p_pv_q; end
			OP_K0PV: begin mul_a = k0_q; mul_b = p_pv_q; end
			OP_K0Y:  begin mul_a = k0_q; mul_b = y_q; end
			OP_K1Y:  begin mul_a = k1_q; mul_b = y_q; end
			OP_DTV:  begin mul_a = step_dt_q; mul_b = vel_q; end
			OP_DTVV: begin mul_a = step_dt_q; mul_b = p_vv_q; end
			OP_DTPV: begin mul_a = step_dt_q; mul_b = p_pv_q; end
			default: begin mul_a = step_dt_q; mul_b = t_q; end
		endcase
	end

	// Product scaled back to the data format, rounded toward minus infinity.
	logic signed [WW-1:0] qm;
	assign qm = WW'(prod_q >>> FB);

	// Sequencer, shared datapath and configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_K0PP;
			cnt_q <= '0;
			div_sel_q <= 1'b0;
			out_valid_q <= 1'b0;
			meas_noise_q <= RST_MEAS_NOISE;
			step_dt_q <= RST_STEP_DT;
			proc_q_pp_q <= '0;
			proc_q_pv_q <= '0;
			proc_q_vv_q <= '0;
			drive_pos_q <= '0;
			drive_vel_q <= '0;
			init_cov_q <= RST_INIT_COV;
			pos_q <= '0;
			vel_q <= '0;
			p_pp_q <= DW'(RST_INIT_COV);
			p_pv_q <= '0;
			p_vv_q <= DW'(RST_INIT_COV);
		end else begin
			// The output state reloads the register itself when the beat leaves.
			if (result.valid && result.ready && state_q != ST_OUT) out_valid_q <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_index)
					REG_MEAS_NOISE: meas_noise_q <= cfg_data[VW-1:0];
					REG_STEP_DT:    step_dt_q <= cfg_data;
					REG_PROC_Q_PP:  proc_q_pp_q <= cfg_data[VW-1:0];
					REG_PROC_Q_PV:  proc_q_pv_q <= cfg_data;
					REG_PROC_Q_VV:  proc_q_vv_q <= cfg_data[VW-1:0];
					REG_DRIVE_POS:  drive_pos_q <= cfg_data;
					REG_DRIVE_VEL:  drive_vel_q <= cfg_data;
					REG_INIT_COV: begin
						init_cov_q <= cfg_data[VW-1:0];
						p_pp_q <= DW'(cfg_data[VW-1:0]);
						p_pv_q <= '0;
						p_vv_q <= DW'(cfg_data[VW-1:0]);
					end
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						s_q <= s_new;
						fault_q <= fault_new;
						y_q <= y_new;
						rem_q <= '0;
						cnt_q <= '0;
						div_sel_q <= 1'b0;
						div_neg_q <= 1'b0;
						num_q <= {p_pp_q, FB'(0)};
						if (fault_new) begin
							op_q <= OP_DTV;
							state_q <= ST_MUL;
						end else begin
							op_q <= OP_K0PP;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rem_q <= ge ? SW'(trial - {1'b0, s_q}) : trial[SW-1:0];
					num_q <= quot;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						cnt_q <= '0;
						rem_q <= '0;
						if (!div_sel_q) begin
							k0_q <= k_new;
							div_sel_q <= 1'b1;
							div_neg_q <= p_pv_q[DW-1];
							num_q <= {pv_mag, FB'(0)};
						end else begin
							k1_q <= k_new;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					prod_q <= mul_a * mul_b;
					state_q <= ST_WB;
				end
				ST_WB: begin
					case (op_q)
						OP_K0PP: p_pp_q <= sat_u(WW'(p_pp_q) - qm);
						OP_K1PV: p_vv_q <= sat_u(WW'(p_vv_q) - qm);
						OP_K0PV: p_pv_q <= sat_s(WW'(p_pv_q) - qm);
						OP_K0Y:  pos_q <= sat_s(WW'(pos_q) + qm);
						OP_K1Y:  vel_q <= sat_s(WW'(vel_q) + qm);
						OP_DTV: begin
							pos_q <= sat_s(WW'(pos_q) + qm + WW'(drive_pos_q));
							vel_q <= sat_s(WW'(vel_q) + WW'(drive_vel_q));
						end
						OP_DTVV: t_q <= sat_s(WW'(p_pv_q) + qm);
						OP_DTPV: acc_q <= WW'(p_pp_q) + qm;
						default: begin
							p_pp_q <= sat_u(acc_q + qm + WW'(proc_q_pp_q));
							p_pv_q <= sat_s(WW'(t_q) + WW'(proc_q_pv_q));
							p_vv_q <= sat_u(WW'(p_vv_q) + WW'(proc_q_vv_q));
						end
					endcase
					if (op_q == OP_DTT) begin
						state_q <= ST_OUT;
					end else begin
						op_q <= op_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || result.ready) begin
						out_q.est_pos <= pos_q;
						out_q.est_vel <= vel_q;
						out_q.cov_pp <= p_pp_q[VW-1:0];
						out_q.cov_pv <= p_pv_q;
						out_q.cov_vv <= p_vv_q[VW-1:0];
						out_q.div_fault <= fault_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid = out_valid_q;
	assign result.data = out_q;

	// A zero innovation variance goes straight to the prediction pass.
	`KFCV_ASSERT_NEXT(a_fault_skips, accept && fault_new, state_q == ST_MUL && op_q == OP_DTV, "fault did not skip the update")
	// A beat that needs the update starts with the gain divisions.
	`KFCV_ASSERT_NEXT(a_div_start, accept && !fault_new, state_q == ST_DIV && !div_sel_q, "update did not start dividing")
	// The variances never go negative.
	`KFCV_ASSERT_NOW(a_var_pos, 1'b1, !p_pp_q[DW-1] && !p_vv_q[DW-1], "negative variance")
	// A result is presented once the sequencer leaves its output state.
	`KFCV_ASSERT_NEXT(a_out_load, state_q == ST_OUT && (!out_valid_q || result.ready), out_valid_q && state_q == ST_IDLE, "result not loaded")

endmodule
`default_nettype wire
